FILE: rtl/core/aes128_block_encrypt_top_defines.svh
// Assertion macros shared by the AES-128 checker.
`ifndef AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH
// Checks that a property holds on every clock edge outside reset.
`define AES_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that a property holds on every clock edge, reset included.
`define AES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/core/aes_pkg.sv
// Package with AES-128 types, tables and round functions.
`default_nettype none
package aes_pkg;
   localparam int unsigned NumRounds = 10;
   localparam int unsigned CsrIdxWidth = 1;
   localparam logic [CsrIdxWidth-1:0] CsrKeyHigh = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLow = 1'b1;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] tab [256];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tab[a];
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd0: v = 8'h01;
         4'd1: v = 8'h02;
         4'd2: v = 8'h04;
         4'd3: v = 8'h08;
         4'd4: v = 8'h10;
         4'd5: v = 8'h20;
         4'd6: v = 8'h40;
         4'd7: v = 8'h80;
         4'd8: v = 8'h1b;
         4'd9: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the state sits at bits 127-8i down to 120-8i.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
      return s[127 - 8*i -: 8];
   endfunction

   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] r);
      logic [127:0] n;
      logic [31:0] t;
      t = {sbox(get_byte(k, 13)) ^ rcon(r), sbox(get_byte(k, 14)),
           sbox(get_byte(k, 15)), sbox(get_byte(k, 12))};
      n[127:96] = k[127:96] ^ t;
      n[95:64] = k[95:64] ^ n[127:96];
      n[63:32] = k[63:32] ^ n[95:64];
      n[31:0] = k[31:0] ^ n[63:32];
      return n;
   endfunction

   function automatic logic [127:0] round(input logic [127:0] s, input logic [127:0] k,
                                          input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, 4*c);
         a1 = get_byte(t, 4*c + 1);
         a2 = get_byte(t, 4*c + 2);
         a3 = get_byte(t, 4*c + 3);
         m[127 - 32*c -: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
         m[119 - 32*c -: 8] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
         m[111 - 32*c -: 8] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
         m[103 - 32*c -: 8] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
      end
      return (last ? t : m) ^ k;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/aes_round_cell.sv
// One round cell: an AES round (MixColumns skipped in the last) plus the matching key expansion step.
`default_nettype none
module aes_round_cell #(
   parameter logic [3:0] ROUND_IDX = 4'd0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         valid_in,
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] key_in,
   output logic              valid_out,
   output logic [127:0]      state_out,
   output logic [127:0]      key_out
);
   logic [127:0] rkey;
   logic         valid_ff;
   logic [127:0] state_ff, state_in_c, key_ff;

   assign rkey = aes_pkg::next_key(key_in, ROUND_IDX);
   assign state_in_c = aes_pkg::round(state_in, rkey, ROUND_IDX == 4'(aes_pkg::NumRounds - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in_c;
         key_ff <= rkey;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out = key_ff;
endmodule
`default_nettype wire

FILE: rtl/core/aes128_block_encrypt_top.sv
// AES-128 encryption top level: key registers, entry stage and ten round cells.
//  channel  direction  payload              handshake
//  req_     in         aes_pkg::req_type    req_valid / req_stall
//  rsp_     out        aes_pkg::rsp_type    rsp_valid / rsp_stall
//  csr_     in         64-bit key half      csr_write_enable, no wait
// One block enters per cycle unless req_stall is high. Each block is registered in the
// entry AddRoundKey register at the transfer edge and then in each of the ten round
// cells in turn.
// Synchronous reset clears the key and all valid bits.
// The whole chain holds when the output stage is full and rsp_stall is high.
`default_nettype none
module aes128_block_encrypt_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire aes_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output aes_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [aes_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [63:0]                         csr_write_data
);
   logic [63:0]  key_high_ff, key_low_ff;
   logic         advance;
   logic         valid_ff;
   logic [127:0] state_ff, key_ff;
   logic         cell_valid [aes_pkg::NumRounds+1];
   logic [127:0] cell_state [aes_pkg::NumRounds+1];
   logic [127:0] cell_key [aes_pkg::NumRounds+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            aes_pkg::CsrKeyHigh: key_high_ff <= csr_write_data;
            aes_pkg::CsrKeyLow:  key_low_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= {req_data.block_high, req_data.block_low} ^ {key_high_ff, key_low_ff};
         key_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign cell_valid[0] = valid_ff;
   assign cell_state[0] = state_ff;
   assign cell_key[0] = key_ff;

   for (genvar g = 0; g < aes_pkg::NumRounds; g++) begin : g_cell
      aes_round_cell #(.ROUND_IDX(4'(g))) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(cell_valid[g]), .state_in(cell_state[g]), .key_in(cell_key[g]),
         .valid_out(cell_valid[g+1]), .state_out(cell_state[g+1]),
         .key_out(cell_key[g+1])
      );
   end

   assign rsp_valid = cell_valid[aes_pkg::NumRounds];
   assign rsp_data.cipher_high = cell_state[aes_pkg::NumRounds][127:64];
   assign rsp_data.cipher_low = cell_state[aes_pkg::NumRounds][63:0];
endmodule
`default_nettype wire

FILE: rtl/core/aes_checker.sv
// Port checker for the AES-128 top level and its bind.
`default_nettype none
`include "aes128_block_encrypt_top_defines.svh"
module aes_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire aes_pkg::rsp_type rsp_data
);
   `AES_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
   `AES_ASSERT_CLK(a_stall_only_full, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without a waiting result")
   `AES_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")
endmodule

bind aes128_block_encrypt_top aes_checker u_aes_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
